>>> hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge, skipping edges while reset is high.
`define RDC_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define RDC_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

>>> hdl/rdc_pkg.sv
// Shared constants, types and the digit-to-character function of the radix converter.
package rdc_pkg;

  localparam int VALUE_BITS = 32;
  localparam int MAX_DIGITS = 32;
  localparam int IN_BITS    = 32;
  localparam int WORK_BITS  = (VALUE_BITS < IN_BITS) ? VALUE_BITS : IN_BITS;
  localparam int CNT_BITS   = $clog2(WORK_BITS);
  localparam int IDX_BITS   = $clog2(MAX_DIGITS);
  localparam int COUNT_BITS = $clog2(MAX_DIGITS + 1);
  localparam int DIGIT_BITS = 6;
  localparam int BASE_BITS  = 6;
  localparam int CHAR_BITS  = 7;
  localparam int BASE_MIN   = 2;
  localparam int BASE_MAX   = 36;
  localparam int DEC_DIGITS = 10;

  localparam logic [CHAR_BITS-1:0] CHAR_ZERO = 7'h30;
  localparam logic [CHAR_BITS-1:0] CHAR_A    = 7'h41;

  typedef struct packed {
    logic                  done;
    logic                  quot_zero;
    logic [DIGIT_BITS-1:0] rem;
  } div_stat_t;

  function automatic logic [CHAR_BITS-1:0] digit_to_char(input logic [DIGIT_BITS-1:0] d);
    logic [CHAR_BITS-1:0] dw;
    dw = {1'b0, d};
    if (d < DIGIT_BITS'(DEC_DIGITS)) begin
      return CHAR_ZERO + dw;
    end else if (d < DIGIT_BITS'(BASE_MAX)) begin
      return CHAR_A + (dw - CHAR_BITS'(DEC_DIGITS));
    end else begin
      return CHAR_ZERO;
    end
  endfunction

endpackage

>>> hdl/rdc_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle, quotient kept in place.
module rdc_divider (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 load,
  input  logic [rdc_pkg::WORK_BITS-1:0]        load_value,
  input  logic                                 go,
  input  logic [rdc_pkg::BASE_BITS-1:0]        base,
  output rdc_pkg::div_stat_t                   stat
);

  logic [rdc_pkg::WORK_BITS-1:0]  quot;
  logic [rdc_pkg::DIGIT_BITS-1:0] rem;
  logic [rdc_pkg::CNT_BITS-1:0]   cnt;
  logic                           running;
  logic                           done;
  logic [rdc_pkg::DIGIT_BITS:0]   trial;
  logic [rdc_pkg::DIGIT_BITS:0]   diff;
  logic                           ge;

  // Bring down the next dividend bit and try a subtract.
  assign trial = {rem, quot[rdc_pkg::WORK_BITS-1]};
  assign ge    = trial >= {1'b0, base};
  assign diff  = trial - {1'b0, base};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= !go && running && (cnt == rdc_pkg::CNT_BITS'(rdc_pkg::WORK_BITS - 1));
      if (go) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == rdc_pkg::CNT_BITS'(rdc_pkg::WORK_BITS - 1)) begin
          running <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      quot <= load_value;
    end else if (running) begin
      quot <= {quot[rdc_pkg::WORK_BITS-2:0], ge};
    end
    if (go) begin
      rem <= '0;
    end else if (running) begin
      rem <= ge ? diff[rdc_pkg::DIGIT_BITS-1:0] : trial[rdc_pkg::DIGIT_BITS-1:0];
    end
  end

  assign stat.done      = done;
  assign stat.quot_zero = (quot == '0);
  assign stat.rem       = rem;

endmodule

>>> hdl/rdc_digit_store.sv
// Digit store: one write port, one registered read port.
module rdc_digit_store (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [rdc_pkg::IDX_BITS-1:0]     wr_addr,
  input  logic [rdc_pkg::DIGIT_BITS-1:0]   wr_data,
  input  logic [rdc_pkg::IDX_BITS-1:0]     rd_addr,
  output logic [rdc_pkg::DIGIT_BITS-1:0]   rd_data
);

  logic [rdc_pkg::DIGIT_BITS-1:0] mem [rdc_pkg::MAX_DIGITS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hdl/radix_digit_converter_top.sv
// Top level of the radix converter: control sequencer, divider and digit store.
//
// Usage:
//   Write the radix on the config channel (cfg_valid/cfg_ready, cfg_data) while
//   the block is idle; cfg_ready is high while busy and start are both low, so a
//   radix write never lands on the edge that takes a request. Reset sets the
//   radix to 10.
//   A request is taken at a clock edge with start high and busy low; value is
//   sampled there. Each character comes out for exactly one cycle with strobe
//   high: digit_char holds uppercase ASCII, most significant digit first, and
//   last marks the final character. A radix outside 2..36 gives one result
//   with error and last high and digit_char zero, in the cycle after the request.
//   A zero value gives the single character '0'.
// Operation:
//   Each digit takes one pass of the bit-serial divider, which works through
//   every value bit before the remainder is stored. After the final digit,
//   each character is read from the store and then passes the output register.
// Reset clears the sequencer and the output strobe; the digit store needs no
//   clearing since every digit is written before it is read. The receiver
//   cannot stall: each result is taken in the cycle it is shown.
module radix_digit_converter_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [rdc_pkg::IN_BITS-1:0]        value,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rdc_pkg::BASE_BITS-1:0]      cfg_data,
  output logic                               strobe,
  output logic [rdc_pkg::CHAR_BITS-1:0]      digit_char,
  output logic                               last,
  output logic                               error
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_DIV   = 4'b0010,
    S_FETCH = 4'b0100,
    S_SEND  = 4'b1000
  } state_t;

  state_t                              state;
  state_t                              state_next;
  logic [rdc_pkg::BASE_BITS-1:0]       base;
  logic [rdc_pkg::COUNT_BITS-1:0]      digit_count;
  logic [rdc_pkg::COUNT_BITS-1:0]      count_inc;
  logic [rdc_pkg::IDX_BITS-1:0]        ptr;
  logic                                accept;
  logic                                base_ok;
  logic                                div_go;
  logic                                store_wr;
  logic                                div_last;
  logic [rdc_pkg::DIGIT_BITS-1:0]      rd_data;
  rdc_pkg::div_stat_t                  div_stat;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = !busy && !start;
  assign accept    = start && !busy;
  assign base_ok   = (base >= rdc_pkg::BASE_BITS'(rdc_pkg::BASE_MIN)) &&
                     (base <= rdc_pkg::BASE_BITS'(rdc_pkg::BASE_MAX));
  assign count_inc = digit_count + 1'b1;

  // A digit is stored when the divider is done; it is the last digit when the quotient runs out or the store is full.
  assign store_wr = (state == S_DIV) && div_stat.done;
  assign div_last = div_stat.quot_zero ||
                    (count_inc == rdc_pkg::COUNT_BITS'(rdc_pkg::MAX_DIGITS));

  always_comb begin
    state_next = state;
    div_go     = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept && base_ok) begin
          div_go     = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          if (div_last) begin
            state_next = S_FETCH;
          end else begin
            div_go = 1'b1;
          end
        end
      end
      S_FETCH: begin
        state_next = S_SEND;
      end
      S_SEND: begin
        state_next = (ptr == '0) ? S_IDLE : S_FETCH;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      base   <= rdc_pkg::BASE_BITS'(10);
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      if (cfg_valid && cfg_ready) begin
        base <= cfg_data;
      end
      // Bad radix: answer at once with a single error result; otherwise
      // strobe each character as it leaves the send state.
      strobe <= (accept && !base_ok) || (state == S_SEND);
    end
  end

  // Digit count, read pointer and output payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      digit_count <= '0;
    end else if (store_wr) begin
      digit_count <= count_inc;
    end

    // Start the readout at the most significant digit, then walk down.
    if (store_wr && div_last) begin
      ptr <= digit_count[rdc_pkg::IDX_BITS-1:0];
    end else if (state == S_SEND) begin
      ptr <= ptr - 1'b1;
    end

    if (accept && !base_ok) begin
      digit_char <= '0;
      last       <= 1'b1;
      error      <= 1'b1;
    end else if (state == S_SEND) begin
      digit_char <= rdc_pkg::digit_to_char(rd_data);
      last       <= (ptr == '0);
      error      <= 1'b0;
    end
  end

  rdc_divider u_divider (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .load_value (value[rdc_pkg::WORK_BITS-1:0]),
    .go         (div_go),
    .base       (base),
    .stat       (div_stat)
  );

  rdc_digit_store u_store (
    .clk     (clk),
    .wr_en   (store_wr),
    .wr_addr (digit_count[rdc_pkg::IDX_BITS-1:0]),
    .wr_data (div_stat.rem),
    .rd_addr (ptr),
    .rd_data (rd_data)
  );

endmodule

>>> hdl/rdc_checker.sv
// Port-level checker for the radix converter, bound to the top level.
`include "assert_macros.svh"

module rdc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          strobe,
  input logic [rdc_pkg::CHAR_BITS-1:0] digit_char,
  input logic                          last,
  input logic                          error
);

  `RDC_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> (!busy && !strobe), "not quiet after reset")
  `RDC_ASSERT(a_err_single, clk, rst, (strobe && error) |-> (last && digit_char == '0), "bad error result")
  `RDC_ASSERT(a_char_range, clk, rst, (strobe && !error) |-> ((digit_char >= 7'h30 && digit_char <= 7'h39) || (digit_char >= 7'h41 && digit_char <= 7'h5A)), "character out of range")
  `RDC_ASSERT(a_req_answer, clk, rst, (start && !busy) |=> (busy || (strobe && error)), "request neither started nor rejected")

endmodule

bind radix_digit_converter_top rdc_checker u_rdc_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .strobe     (strobe),
  .digit_char (digit_char),
  .last       (last),
  .error      (error)
);
